@@ sv/tlb_translate_fifo_lru_assert.svh @@
// Assertion macros used by the translation buffer controller.
`ifndef TLB_TRANSLATE_FIFO_LRU_ASSERT_SVH
`define TLB_TRANSLATE_FIFO_LRU_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TLBFL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TLBFL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/tlbfl_pkg.sv @@
`default_nettype none

package tlbfl_pkg;

	localparam int DEF_MAX_ENTRIES = 16;
	localparam int DEF_STAMP_BITS  = 32;

	localparam int PID_W   = 16;
	localparam int PAGE_W  = 20;
	localparam int OFF_W   = 16;
	localparam int FRAME_W = 20;
	localparam int ADDR_W  = 32;
	localparam int PSIZE_W = 17;
	localparam int EIU_W   = 5;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	localparam int S_TDATA_W = 72;
	localparam int M_TDATA_W = 32;

	localparam logic [PSIZE_W-1:0] PSIZE_RESET = 17'd4096;
	localparam logic [EIU_W-1:0]   EIU_RESET   = 5'd16;

	localparam logic REQ_FILL   = 1'b1;
	localparam logic POLICY_LRU = 1'b1;
	localparam logic POLICY_FIFO = 1'b0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAGE_SIZE      = 2'd0,
		REG_ENTRIES_IN_USE = 2'd1,
		REG_REPLACE_POLICY = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic load;     // capture the incoming request
		logic resolve;  // search, pick a victim, install or stamp
		logic scan;     // one step of the LRU stamp scan
		logic emit;     // write the result into the output register
	} tlbfl_cmd_t;

	typedef struct packed {
		logic need_scan;
		logic scan_last;
		logic out_free;
	} tlbfl_status_t;

endpackage

`default_nettype wire

@@ sv/tlbfl_ctrl.sv @@
`default_nettype none
`include "tlb_translate_fifo_lru_assert.svh"

module tlbfl_ctrl import tlbfl_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	output tlbfl_cmd_t         cmd,
	input  wire tlbfl_status_t st
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_SCAN,
		S_CALC
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		state_d  = state_q;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_SEARCH;
				end
			end
			S_SEARCH: begin
				cmd.resolve = 1'b1;
				state_d     = st.need_scan ? S_SCAN : S_CALC;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (st.scan_last) begin
					state_d = S_CALC;
				end
			end
			S_CALC: begin
				// The next request may enter as soon as this result is placed.
				if (st.out_free) begin
					cmd.emit = 1'b1;
					s_tready = 1'b1;
					if (s_tvalid) begin
						cmd.load = 1'b1;
						state_d  = S_SEARCH;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`TLBFL_ASSERT_NEXT(a_accept_search, clk, arst_n, s_tvalid && s_tready, state_q == S_SEARCH, "accepted request did not enter search")
	`TLBFL_ASSERT_NEXT(a_search_to_calc, clk, arst_n, state_q == S_SEARCH && !st.need_scan, state_q == S_CALC, "search without scan did not go to calc")
	`TLBFL_ASSERT_NEXT(a_scan_holds, clk, arst_n, state_q == S_SCAN && !st.scan_last, state_q == S_SCAN, "stamp scan ended early")
	`TLBFL_ASSERT_NEXT(a_calc_stall, clk, arst_n, state_q == S_CALC && !st.out_free, state_q == S_CALC, "result dropped while output was full")

endmodule

`default_nettype wire

@@ sv/tlbfl_dp.sv @@
`default_nettype none

module tlbfl_dp import tlbfl_pkg::*; #(
	parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
	parameter int STAMP_BITS  = DEF_STAMP_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire tlbfl_cmd_t           cmd,
	output tlbfl_status_t             st,
	// s_tdata: process_id, page_number, page_offset, fill_frame (lowest first)
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	// s_tuser: req_type
	input  wire logic                 s_tuser,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// m_tdata: physical_address
	output logic [M_TDATA_W-1:0]      m_tdata,
	// m_tuser: hit
	output logic                      m_tuser,
	input  wire logic [PSIZE_W-1:0]   page_size,
	input  wire logic [EIU_W-1:0]     entries_in_use,
	input  wire logic                 replace_policy
);

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int LIM_W = (CNT_W > EIU_W) ? CNT_W : EIU_W;
	localparam int PROD_W = FRAME_W + PSIZE_W;

	// Request register.
	logic               req_fill_q;
	logic [PID_W-1:0]   req_pid_q;
	logic [PAGE_W-1:0]  req_page_q;
	logic [OFF_W-1:0]   req_off_q;
	logic [FRAME_W-1:0] req_frame_q;

	// Entry store.
	logic                  valid_q [MAX_ENTRIES];
	logic [PID_W-1:0]      pid_q   [MAX_ENTRIES];
	logic [PAGE_W-1:0]     page_q  [MAX_ENTRIES];
	logic [FRAME_W-1:0]    frame_q [MAX_ENTRIES];
	logic [STAMP_BITS-1:0] stamp_q [MAX_ENTRIES];
	logic [IDX_W-1:0]      ptr_q;
	logic [STAMP_BITS-1:0] use_q;

	logic               hit_q;
	logic [FRAME_W-1:0] frame_sel_q;

	logic [IDX_W-1:0]      cand_q;
	logic [STAMP_BITS-1:0] cand_stamp_q;
	logic [IDX_W-1:0]      scan_idx_q;

	logic                 m_tvalid_q;
	logic [ADDR_W-1:0]    m_tdata_q;
	logic                 m_tuser_q;

	logic [LIM_W-1:0] eiu_ext;
	logic [CNT_W-1:0] live_n;
	logic             is_lru;
	logic             n_zero;
	logic             n_one;

	logic [MAX_ENTRIES-1:0] match;
	logic [MAX_ENTRIES-1:0] free;
	logic [MAX_ENTRIES-1:0] match_oh;
	logic [MAX_ENTRIES-1:0] free_oh;
	logic                   any_hit;
	logic                   any_free;
	logic [IDX_W-1:0]       hit_idx;
	logic [IDX_W-1:0]       free_idx;

	logic [IDX_W-1:0] fifo_v;
	logic [CNT_W-1:0] fifo_v1;
	logic [IDX_W-1:0] fifo_next;

	logic [STAMP_BITS-1:0] scan_rd;
	logic                  scan_take;
	logic [IDX_W-1:0]      nxt_cand;
	logic                  scan_last;
	logic                  need_scan;

	logic             inst_en;
	logic [IDX_W-1:0] inst_idx;
	logic             stamp_we;
	logic [IDX_W-1:0] stamp_idx;
	logic             ptr_we;

	logic [PROD_W-1:0] prod;
	logic [ADDR_W-1:0] addr;

	assign eiu_ext = LIM_W'(entries_in_use);
	assign live_n  = (eiu_ext > LIM_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : CNT_W'(eiu_ext);
	assign is_lru  = (replace_policy == POLICY_LRU);
	assign n_zero  = (live_n == '0);
	assign n_one   = (live_n == CNT_W'(1));

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cmp
		logic in_range;
		assign in_range = (CNT_W'(i) < live_n);
		assign match[i] = valid_q[i] && in_range && (pid_q[i] == req_pid_q)
			&& (page_q[i] == req_page_q);
		// Entry 0 is the starting LRU candidate and is never picked as a free slot.
		assign free[i]  = (i != 0) && in_range && !valid_q[i];
	end

	// Isolate the lowest set bit, then encode the one-hot vector.
	assign match_oh = match & (~match + MAX_ENTRIES'(1));
	assign free_oh  = free & (~free + MAX_ENTRIES'(1));
	assign any_hit  = |match;
	assign any_free = |free;

	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (match_oh[i]) begin
				hit_idx = hit_idx | IDX_W'(i);
			end
			if (free_oh[i]) begin
				free_idx = free_idx | IDX_W'(i);
			end
		end
	end

	// A pointer left beyond a shrunk entry count restarts at entry 0.
	assign fifo_v    = (CNT_W'(ptr_q) < live_n) ? ptr_q : '0;
	assign fifo_v1   = CNT_W'(fifo_v) + CNT_W'(1);
	assign fifo_next = (fifo_v1 == live_n) ? '0 : IDX_W'(fifo_v1);

	assign scan_rd   = stamp_q[scan_idx_q];
	assign scan_take = (scan_rd < cand_stamp_q);
	assign nxt_cand  = scan_take ? scan_idx_q : cand_q;
	assign scan_last = (CNT_W'(scan_idx_q) == (live_n - CNT_W'(1)));
	assign need_scan = req_fill_q && is_lru && !n_zero && !any_free && !n_one;

	always_comb begin
		inst_en   = 1'b0;
		inst_idx  = '0;
		stamp_we  = 1'b0;
		stamp_idx = '0;
		ptr_we    = 1'b0;
		if (cmd.resolve) begin
			if (req_fill_q != REQ_FILL) begin
				if (any_hit && is_lru) begin
					stamp_we  = 1'b1;
					stamp_idx = hit_idx;
				end
			end else if (!n_zero) begin
				if (!is_lru) begin
					inst_en  = 1'b1;
					inst_idx = fifo_v;
					ptr_we   = 1'b1;
				end else if (any_free) begin
					inst_en   = 1'b1;
					inst_idx  = free_idx;
					stamp_we  = 1'b1;
					stamp_idx = free_idx;
				end else if (n_one) begin
					inst_en   = 1'b1;
					inst_idx  = '0;
					stamp_we  = 1'b1;
					stamp_idx = '0;
				end
			end
		end else if (cmd.scan && scan_last) begin
			inst_en   = 1'b1;
			inst_idx  = nxt_cand;
			stamp_we  = 1'b1;
			stamp_idx = nxt_cand;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				valid_q[i] <= 1'b0;
				stamp_q[i] <= '0;
			end
			ptr_q <= '0;
			use_q <= '0;
		end else begin
			if (inst_en) begin
				valid_q[inst_idx] <= 1'b1;
			end
			if (stamp_we) begin
				stamp_q[stamp_idx] <= use_q;
				use_q              <= use_q + STAMP_BITS'(1);
			end
			if (ptr_we) begin
				ptr_q <= fifo_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (inst_en) begin
			pid_q[inst_idx]   <= req_pid_q;
			page_q[inst_idx]  <= req_page_q;
			frame_q[inst_idx] <= req_frame_q;
		end
		if (cmd.load) begin
			req_fill_q  <= s_tuser;
			req_pid_q   <= s_tdata[PID_W-1:0];
			req_page_q  <= s_tdata[PID_W +: PAGE_W];
			req_off_q   <= s_tdata[PID_W+PAGE_W +: OFF_W];
			req_frame_q <= s_tdata[PID_W+PAGE_W+OFF_W +: FRAME_W];
		end
		if (cmd.resolve) begin
			hit_q        <= (req_fill_q == REQ_FILL) || any_hit;
			frame_sel_q  <= (req_fill_q == REQ_FILL) ? req_frame_q : frame_q[hit_idx];
			cand_q       <= '0;
			cand_stamp_q <= stamp_q[0];
			scan_idx_q   <= IDX_W'(1);
		end
		if (cmd.scan) begin
			cand_q       <= nxt_cand;
			cand_stamp_q <= scan_take ? scan_rd : cand_stamp_q;
			scan_idx_q   <= scan_idx_q + IDX_W'(1);
		end
	end

	assign prod = frame_sel_q * page_size;
	assign addr = prod[ADDR_W-1:0] + ADDR_W'(req_off_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			m_tdata_q <= hit_q ? addr : '0;
			m_tuser_q <= hit_q;
		end
	end

	assign st.need_scan = need_scan;
	assign st.scan_last = scan_last;
	assign st.out_free  = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

`default_nettype wire

@@ sv/tlb_translate_fifo_lru.sv @@
// Fully associative TLB keyed by process id and page number, with FIFO or
// LRU replacement. A translate request (s_tuser low) is searched against all
// in-use entries at once; a hit returns frame * page_size + offset
// modulo 2^32 with m_tuser high, a miss returns m_tuser low and address 0.
// A fill request (s_tuser high) returns its address and, while any entry is
// in use, installs its frame. A request is captured, searched, then its
// address is multiplied and added into the output register; the next request
// is accepted only as that result is placed, and a full output stalls it.
// An LRU fill with more than one entry in use and every in-use slot from 1
// up occupied walks the stamps of those entries, one entry per cycle.
// Configuration writes are taken at any edge but are meant for idle periods.
`default_nettype none

module tlb_translate_fifo_lru import tlbfl_pkg::*; #(
	parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
	parameter int STAMP_BITS  = DEF_STAMP_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// s_tdata: process_id, page_number, page_offset, fill_frame (lowest first)
	input  wire logic [S_TDATA_W-1:0]  s_tdata,
	// s_tuser: req_type
	input  wire logic                  s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// m_tdata: physical_address
	output logic [M_TDATA_W-1:0]       m_tdata,
	// m_tuser: hit
	output logic                       m_tuser
);

	logic [PSIZE_W-1:0] page_size_q;
	logic [EIU_W-1:0]   entries_q;
	logic               policy_q;

	tlbfl_cmd_t    cmd;
	tlbfl_status_t st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_size_q <= PSIZE_RESET;
			entries_q   <= EIU_RESET;
			policy_q    <= POLICY_FIFO;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PAGE_SIZE:      page_size_q <= cfg_data[PSIZE_W-1:0];
				REG_ENTRIES_IN_USE: entries_q   <= cfg_data[EIU_W-1:0];
				REG_REPLACE_POLICY: policy_q    <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	tlbfl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.st       (st)
	);

	tlbfl_dp #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.STAMP_BITS  (STAMP_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.page_size      (page_size_q),
		.entries_in_use (entries_q),
		.replace_policy (policy_q)
	);

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
	import tlbfl_pkg::*;

	localparam logic REQ_LOOKUP = 1'b0;
	localparam int   CYCLE_LIMIT = 600000;
	// Long enough for an LRU fill that walks every stamp, plus the output stage.
	localparam int   SETTLE_CYCLES = DEF_MAX_ENTRIES + 8;
	localparam int   HOLD_AFTER_RESULTS = 200;
	localparam int   HOLD_CYCLES = 400;

	// Field order of s_tdata, highest field first so that process_id lands at bit 0.
	typedef struct packed {
		logic [FRAME_W-1:0] frame;
		logic [OFF_W-1:0]   offset;
		logic [PAGE_W-1:0]  page;
		logic [PID_W-1:0]   pid;
	} xlat_request_t;

	typedef struct packed {
		logic              hit;
		logic [ADDR_W-1:0] addr;
	} xlat_result_t;

	class tlb_scoreboard;
		logic [PSIZE_W-1:0] page_size;
		logic [EIU_W-1:0]   entries_in_use;
		logic               policy;
		bit                 slot_valid [DEF_MAX_ENTRIES];
		logic [PID_W-1:0]   slot_pid   [DEF_MAX_ENTRIES];
		logic [PAGE_W-1:0]  slot_page  [DEF_MAX_ENTRIES];
		logic [FRAME_W-1:0] slot_frame [DEF_MAX_ENTRIES];
		logic [31:0]        slot_stamp [DEF_MAX_ENTRIES];
		logic [3:0]         fifo_ptr;
		logic [31:0]        use_count;
		xlat_result_t       pending_results [$];
		int                 mismatches;
		int                 results_seen;

		function new();
			page_size = PSIZE_RESET;
			entries_in_use = EIU_RESET;
			policy = POLICY_FIFO;
			for (int i = 0; i < DEF_MAX_ENTRIES; i++) begin
				slot_valid[i] = 0;
				slot_pid[i] = '0;
				slot_page[i] = '0;
				slot_frame[i] = '0;
				slot_stamp[i] = '0;
			end
			fifo_ptr = '0;
			use_count = '0;
			mismatches = 0;
			results_seen = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				REG_PAGE_SIZE: begin
					page_size = value[PSIZE_W-1:0];
				end
				REG_ENTRIES_IN_USE: begin
					entries_in_use = value[EIU_W-1:0];
				end
				REG_REPLACE_POLICY: begin
					policy = value[0];
				end
				default: begin
				end
			endcase
		endfunction

		function logic [ADDR_W-1:0] phys_addr(logic [FRAME_W-1:0] frame,
			logic [OFF_W-1:0] offset);
			return ADDR_W'(frame) * ADDR_W'(page_size) + ADDR_W'(offset);
		endfunction

		function logic [31:0] next_stamp();
			logic [31:0] s;
			s = use_count;
			use_count = use_count + 1;
			return s;
		endfunction

		function int choose_victim(int n);
			int v;
			if (policy == POLICY_FIFO) begin
				v = (fifo_ptr < n) ? int'(fifo_ptr) : 0;
				fifo_ptr = 4'((v + 1) % n);
				return v;
			end
			// Entry 0 is the starting candidate whether or not it is valid.
			v = 0;
			for (int i = 1; i < n; i++) begin
				if (!slot_valid[i]) begin
					v = i;
					break;
				end
				if (slot_stamp[i] < slot_stamp[v])
					v = i;
			end
			slot_stamp[v] = next_stamp();
			return v;
		endfunction

		function xlat_result_t translate(logic kind, xlat_request_t req);
			xlat_result_t res;
			int n;
			int v;
			n = (entries_in_use > DEF_MAX_ENTRIES) ? DEF_MAX_ENTRIES : int'(entries_in_use);
			if (kind != REQ_FILL) begin
				for (int i = 0; i < n; i++) begin
					if (slot_valid[i] && slot_pid[i] == req.pid && slot_page[i] == req.page) begin
						if (policy == POLICY_LRU)
							slot_stamp[i] = next_stamp();
						res.hit = 1'b1;
						res.addr = phys_addr(slot_frame[i], req.offset);
						return res;
					end
				end
				res.hit = 1'b0;
				res.addr = '0;
				return res;
			end
			if (n > 0) begin
				v = choose_victim(n);
				slot_valid[v] = 1;
				slot_pid[v] = req.pid;
				slot_page[v] = req.page;
				slot_frame[v] = req.frame;
			end
			res.hit = 1'b1;
			res.addr = phys_addr(req.frame, req.offset);
			return res;
		endfunction

		function void note_request(logic kind, xlat_request_t req);
			pending_results.push_back(translate(kind, req));
		endfunction

		function void check_result(logic hit, logic [ADDR_W-1:0] addr);
			xlat_result_t exp_res;
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("result with no request waiting: hit %0d physical_address 0x%08h",
					hit, addr);
				mismatches++;
				return;
			end
			exp_res = pending_results.pop_front();
			if (hit !== exp_res.hit) begin
				$error("hit: expected %0d, got %0d", exp_res.hit, hit);
				mismatches++;
			end
			if (addr !== exp_res.addr) begin
				$error("physical_address: expected 0x%08h, got 0x%08h", exp_res.addr, addr);
				mismatches++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	cfg_reg_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  m_tuser;

	tlb_scoreboard sb = new();
	bit steady_flow = 0;
	int cycle_count = 0;

	tlb_translate_fifo_lru DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tlb_translate_fifo_lru verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_request(s_tuser, xlat_request_t'(s_tdata));
			if (m_tvalid && m_tready)
				sb.check_result(m_tuser, m_tdata);
		end
	end

	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_request(input logic kind, input logic [PID_W-1:0] pid,
		input logic [PAGE_W-1:0] page, input logic [OFF_W-1:0] offset,
		input logic [FRAME_W-1:0] frame);
		xlat_request_t req;
		int gap;
		gap = steady_flow ? 0 : idle_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.pid = pid;
		req.page = page;
		req.offset = offset;
		req.frame = frame;
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= req;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// The task first waits for the clock so that the monitor has noted the last accepted request.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// All three registers are rewritten, one per cycle, once the pipeline has drained.
	task automatic configure(input logic [PSIZE_W-1:0] psize, input logic [EIU_W-1:0] eiu,
		input logic policy);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= REG_PAGE_SIZE;
		cfg_data <= CFG_DATA_W'(psize);
		sb.set_reg(REG_PAGE_SIZE, CFG_DATA_W'(psize));
		@(posedge clk);
		cfg_index <= REG_ENTRIES_IN_USE;
		cfg_data <= CFG_DATA_W'(eiu);
		sb.set_reg(REG_ENTRIES_IN_USE, CFG_DATA_W'(eiu));
		@(posedge clk);
		cfg_index <= REG_REPLACE_POLICY;
		cfg_data <= CFG_DATA_W'(policy);
		sb.set_reg(REG_REPLACE_POLICY, CFG_DATA_W'(policy));
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Most traffic reuses a small set of pid/page pairs so that hits, evictions and
	// lookup-then-fill sequences dominate; the rest is fully random noise.
	task automatic run_random(input int count, input int pool_size);
		logic [PID_W-1:0]  pool_pid  [32];
		logic [PAGE_W-1:0] pool_page [32];
		int sent;
		int r;
		int k;
		for (int i = 0; i < pool_size; i++) begin
			pool_pid[i] = $urandom_range(0, 1) ? PID_W'($urandom_range(1, 65535))
				: PID_W'($urandom_range(1, 4));
			pool_page[i] = $urandom_range(0, 1) ? PAGE_W'($urandom)
				: PAGE_W'($urandom_range(0, 7));
		end
		sent = 0;
		while (sent < count) begin
			r = $urandom_range(0, 99);
			k = $urandom_range(0, pool_size - 1);
			if ($urandom_range(0, 19) == 0) begin
				pool_pid[k] = PID_W'($urandom_range(1, 65535));
				pool_page[k] = PAGE_W'($urandom);
			end
			if (r < 10) begin
				send_request(1'($urandom), PID_W'($urandom), PAGE_W'($urandom),
					OFF_W'($urandom), FRAME_W'($urandom));
				sent++;
			end else if (r < 60) begin
				send_request(REQ_LOOKUP, pool_pid[k], pool_page[k], OFF_W'($urandom), '0);
				sent++;
			end else if (r < 88) begin
				send_request(REQ_LOOKUP, pool_pid[k], pool_page[k], OFF_W'($urandom), '0);
				send_request(REQ_FILL, pool_pid[k], pool_page[k], OFF_W'($urandom),
					FRAME_W'($urandom));
				sent += 2;
			end else begin
				send_request(REQ_FILL, pool_pid[k], pool_page[k], OFF_W'($urandom),
					FRAME_W'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		int stall;
		int run;
		bit held;
		held = 0;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			// One long hold-off lets the block fill up and stall new requests.
			if (!held && sb.results_seen >= HOLD_AFTER_RESULTS) begin
				held = 1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			stall = (!steady_flow && $urandom_range(0, 2) == 0) ? idle_gap() : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			run = $urandom_range(1, 16);
			repeat (run) @(posedge clk);
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_PAGE_SIZE;
		cfg_data <= '0;
		s_tvalid <= 1'b0;
		s_tuser <= REQ_LOOKUP;
		s_tdata <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: 4 KiB pages, all sixteen entries, FIFO.
		send_request(REQ_LOOKUP, 16'd1, 20'd0, 16'd0, 20'd0);
		send_request(REQ_FILL, 16'd1, 20'd0, 16'hFFFF, 20'hFFFFF);
		send_request(REQ_LOOKUP, 16'd1, 20'd0, 16'hFFFF, 20'd0);
		send_request(REQ_FILL, 16'hFFFF, 20'hFFFFF, 16'd0, 20'd0);
		send_request(REQ_LOOKUP, 16'hFFFF, 20'hFFFFF, 16'h1234, 20'hFFFFF);
		// A duplicate fill; the lookup must still find the lower entry.
		send_request(REQ_FILL, 16'd1, 20'd0, 16'd7, 20'd5);
		send_request(REQ_LOOKUP, 16'd1, 20'd0, 16'd0, 20'd0);
		// Empty entries are not valid, so a lookup of pid 0, page 0 misses.
		send_request(REQ_LOOKUP, 16'd0, 20'd0, 16'd0, 20'd0);

		// Shrinking to two entries hides the duplicate and restarts the FIFO pointer.
		configure(17'd4096, 5'd2, POLICY_FIFO);
		send_request(REQ_FILL, 16'd2, 20'd2, 16'd0, 20'd9);
		send_request(REQ_LOOKUP, 16'd1, 20'd0, 16'd0, 20'd0);
		send_request(REQ_LOOKUP, 16'd2, 20'd2, 16'h8000, 20'd0);

		// With no entries a lookup misses and a fill is not installed; page size 0 leaves only the offset.
		configure(17'd0, 5'd0, POLICY_FIFO);
		send_request(REQ_LOOKUP, 16'hFFFF, 20'hFFFFF, 16'd3, 20'd0);
		send_request(REQ_FILL, 16'd3, 20'd3, 16'hABCD, 20'h12345);

		// Count above the maximum saturates; oversize page wraps the product.
		configure(17'h1FFFF, 5'd31, POLICY_LRU);
		send_request(REQ_FILL, 16'd4, 20'd4, 16'd1, 20'd1);
		send_request(REQ_LOOKUP, 16'd2, 20'd2, 16'd0, 20'd0);
		send_request(REQ_FILL, 16'd5, 20'd5, 16'hFFFF, 20'hFFFFF);
		send_request(REQ_LOOKUP, 16'd5, 20'd5, 16'hFFFF, 20'd0);

		// A single entry in LRU mode, then in FIFO mode, always reuses slot 0.
		configure(17'h10000, 5'd1, POLICY_LRU);
		send_request(REQ_FILL, 16'd6, 20'd6, 16'd2, 20'hFFFFF);
		send_request(REQ_FILL, 16'd7, 20'd7, 16'd2, 20'h00010);
		send_request(REQ_LOOKUP, 16'd7, 20'd7, 16'd9, 20'd0);
		configure(17'h10000, 5'd1, POLICY_FIFO);
		send_request(REQ_FILL, 16'd8, 20'd8, 16'd0, 20'd1);
		send_request(REQ_LOOKUP, 16'd8, 20'd8, 16'd1, 20'd0);

		configure(17'd4096, 5'd16, POLICY_FIFO);
		run_random(240, 20);
		configure(PSIZE_W'($urandom_range(1, 65536)), 5'd16, POLICY_LRU);
		run_random(240, 20);
		configure(17'h10000, 5'd5, POLICY_LRU);
		run_random(240, 8);
		steady_flow = 1;
		configure(17'd1, 5'd3, POLICY_FIFO);
		run_random(240, 6);
		steady_flow = 0;
		configure(17'h1FFFF, 5'd31, POLICY_LRU);
		run_random(240, 22);

		wait_idle();
		if (sb.mismatches == 0 && sb.pending_results.size() == 0)
			$display("tlb_translate_fifo_lru verification clean");
		else
			$display("tlb_translate_fifo_lru verification failed");
		$finish;
	end

endmodule
